[design/assert_macros.svh]
// Assertion macros for the design files; sustain_pedal_note_holder uses them.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define AST_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition never holds
`define AST_NEVER(lbl, cond, msg) \
  `AST_PROP(lbl, !(cond), msg)

`endif

[design/spnh_pkg.sv]
// Types, constants and microcode table of the sustain pedal note holder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spnh_pkg;

  localparam int unsigned NoteW = 7;
  localparam int unsigned ReqW  = 3;
  localparam int unsigned PcW   = 4;

  typedef enum logic [ReqW-1:0] {
    REQ_PITCH = 3'd0,
    REQ_VEL   = 3'd1,
    REQ_PEDAL = 3'd2,
    REQ_LIST  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_SETPED,
    OP_POP,
    OP_EMIT,
    OP_SETVEL,
    OP_PITCH,
    OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_PED_NZ,
    C_CNT_Z,
    C_DISPATCH
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           last_ok;
  } ucode_t;

  typedef struct packed {
    logic            accept;
    logic [ReqW-1:0] req_type;
    logic            ped_nz;
    logic            cnt_z;
    logic            stall;
  } stat_t;

  localparam logic [PcW-1:0] STEP_IDLE   = 4'd0;
  localparam logic [PcW-1:0] STEP_P_SET  = 4'd1;
  localparam logic [PcW-1:0] STEP_P_POP  = 4'd2;
  localparam logic [PcW-1:0] STEP_P_EMIT = 4'd3;
  localparam logic [PcW-1:0] STEP_L_SET  = 4'd4;
  localparam logic [PcW-1:0] STEP_L_POP  = 4'd5;
  localparam logic [PcW-1:0] STEP_L_EMIT = 4'd6;
  localparam logic [PcW-1:0] STEP_L_VEL  = 4'd7;
  localparam logic [PcW-1:0] STEP_PITCH  = 4'd8;
  localparam logic [PcW-1:0] STEP_VEL    = 4'd9;
  localparam logic [PcW-1:0] STEP_CLR    = 4'd10;

  function automatic ucode_t ucode_rom(input logic [PcW-1:0] pc);
    ucode_t w;
    w = '{op: OP_WAIT, cond: C_DISPATCH, target: STEP_IDLE, last_ok: 1'b0};
    case (pc)
      STEP_P_SET:  w = '{op: OP_SETPED, cond: C_PED_NZ, target: STEP_IDLE,  last_ok: 1'b0};
      STEP_P_POP:  w = '{op: OP_POP,    cond: C_CNT_Z,  target: STEP_IDLE,  last_ok: 1'b0};
      STEP_P_EMIT: w = '{op: OP_EMIT,   cond: C_ALWAYS, target: STEP_P_POP, last_ok: 1'b1};
      STEP_L_SET:  w = '{op: OP_SETPED, cond: C_PED_NZ, target: STEP_L_VEL, last_ok: 1'b0};
      STEP_L_POP:  w = '{op: OP_POP,    cond: C_CNT_Z,  target: STEP_L_VEL, last_ok: 1'b0};
      STEP_L_EMIT: w = '{op: OP_EMIT,   cond: C_ALWAYS, target: STEP_L_POP, last_ok: 1'b0};
      STEP_L_VEL:  w = '{op: OP_SETVEL, cond: C_NEXT,   target: STEP_IDLE,  last_ok: 1'b0};
      STEP_PITCH:  w = '{op: OP_PITCH,  cond: C_ALWAYS, target: STEP_IDLE,  last_ok: 1'b0};
      STEP_VEL:    w = '{op: OP_SETVEL, cond: C_ALWAYS, target: STEP_IDLE,  last_ok: 1'b0};
      STEP_CLR:    w = '{op: OP_CLEAR,  cond: C_ALWAYS, target: STEP_IDLE,  last_ok: 1'b0};
      default:     w = '{op: OP_WAIT, cond: C_DISPATCH, target: STEP_IDLE, last_ok: 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [PcW-1:0] entry_pc(input logic [ReqW-1:0] req);
    logic [PcW-1:0] pc;
    case (req)
      REQ_PITCH: pc = STEP_PITCH;
      REQ_VEL:   pc = STEP_VEL;
      REQ_PEDAL: pc = STEP_P_SET;
      REQ_LIST:  pc = STEP_L_SET;
      REQ_CLEAR: pc = STEP_CLR;
      default:   pc = STEP_IDLE;
    endcase
    return pc;
  endfunction

endpackage
`default_nettype wire

[design/spnh_if.sv]
// Valid/ready channel interfaces for request and note transactions.
// Depends on spnh_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface spnh_in_if;
  import spnh_pkg::*;
  logic             valid;
  logic             ready;
  logic [ReqW-1:0]  req_type;
  logic [NoteW-1:0] note_pitch;
  logic [NoteW-1:0] note_velocity;
  logic [NoteW-1:0] pedal_level;
  modport source (output valid, req_type, note_pitch, note_velocity, pedal_level,
                  input ready);
  modport sink   (input valid, req_type, note_pitch, note_velocity, pedal_level,
                  output ready);
endinterface

interface spnh_out_if;
  import spnh_pkg::*;
  logic             valid;
  logic             ready;
  logic [NoteW-1:0] out_pitch;
  logic [NoteW-1:0] out_velocity;
  logic             last_of_run;
  logic             overflow;
  modport source (output valid, out_pitch, out_velocity, last_of_run, overflow,
                  input ready);
  modport sink   (input valid, out_pitch, out_velocity, last_of_run, overflow,
                  output ready);
endinterface
`default_nettype wire

[design/sustain_pedal_note_holder.sv]
// Sustain pedal note holder: request latch, hold stack and note output register.
// Depends on spnh_pkg, spnh_if, spnh_useq and assert_macros.svh.
//
// Takes one request transaction at a time and answers with note transactions.
// A pedal release, also one within a list request, drains the held notes;
// each held note costs two microcode steps, one to read the stack memory
// through its registered read port and one to load the output register.
// Notes wait in a single output register, so a slow sink stalls the drain
// loop but never the acceptance of the next request once the sequencer is
// back at its idle step.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sustain_pedal_note_holder #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spnh_in_if.sink     in_i,
  spnh_out_if.source  out_o
);
  import spnh_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  ucode_t ctrl;
  stat_t  stat;

  logic [ReqW-1:0]  req_q;
  logic [NoteW-1:0] pitch_q, vel_in_q, ped_in_q;
  logic [NoteW-1:0] vel_q, vel_d, pedal_q, pedal_d;
  logic [CW-1:0]    cnt_q, cnt_d, cnt_m1;
  logic [NoteW-1:0] mem [STACK_DEPTH];
  logic [NoteW-1:0] rd_q;
  logic             accept, cnt_z, cnt_full, stall, push, pop;
  logic             load, ovf_d, last_d;
  logic [NoteW-1:0] opitch_d, ovel_d;
  logic             out_v_q, out_v_d;
  logic [NoteW-1:0] opitch_q, ovel_q;
  logic             olast_q, oovf_q;

  spnh_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign in_i.ready = (ctrl.op == OP_WAIT);
  assign accept     = in_i.valid && in_i.ready;
  assign cnt_z      = (cnt_q == '0);
  assign cnt_full   = (cnt_q >= CW'(STACK_DEPTH));
  assign cnt_m1     = cnt_q - 1'b1;
  assign stall      = ((ctrl.op == OP_EMIT) || (ctrl.op == OP_PITCH)) &&
                      out_v_q && !out_o.ready;

  assign stat = '{accept: accept, req_type: in_i.req_type, ped_nz: (ped_in_q != '0),
                  cnt_z: cnt_z, stall: stall};

  always_comb begin
    vel_d    = vel_q;
    pedal_d  = pedal_q;
    cnt_d    = cnt_q;
    push     = 1'b0;
    pop      = 1'b0;
    load     = 1'b0;
    opitch_d = pitch_q;
    ovel_d   = '0;
    last_d   = 1'b0;
    ovf_d    = 1'b0;
    if (!stall) begin
      case (ctrl.op)
        OP_SETPED: pedal_d = ped_in_q;
        OP_SETVEL: vel_d = vel_in_q;
        OP_CLEAR:  cnt_d = '0;
        OP_POP: begin
          if (!cnt_z) begin
            pop   = 1'b1;
            cnt_d = cnt_m1;
          end
        end
        OP_EMIT: begin
          load     = 1'b1;
          opitch_d = rd_q;
          last_d   = ctrl.last_ok && cnt_z;
        end
        OP_PITCH: begin
          if ((vel_q != '0) || (pedal_q == '0)) begin
            load   = 1'b1;
            ovel_d = vel_q;
            last_d = 1'b1;
          end else if (!cnt_full) begin
            push  = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            load   = 1'b1;
            last_d = 1'b1;
            ovf_d  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (load) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q   <= '0;
      pedal_q <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      vel_q   <= vel_d;
      pedal_q <= pedal_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= in_i.req_type;
      pitch_q  <= in_i.note_pitch;
      vel_in_q <= in_i.note_velocity;
      ped_in_q <= in_i.pedal_level;
    end
    if (load) begin
      opitch_q <= opitch_d;
      ovel_q   <= ovel_d;
      olast_q  <= last_d;
      oovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[cnt_q[AW-1:0]] <= pitch_q;
    end
    if (pop) begin
      rd_q <= mem[cnt_m1[AW-1:0]];
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.out_pitch    = opitch_q;
  assign out_o.out_velocity = ovel_q;
  assign out_o.last_of_run  = olast_q;
  assign out_o.overflow     = oovf_q;

  `AST_NEVER(a_cnt_bound, cnt_q > CW'(STACK_DEPTH), "hold count above stack depth")
  `AST_PROP(a_ovf_full, (load && ovf_d) |-> (cnt_q == CW'(STACK_DEPTH)), "overflow with room")
  `AST_PROP(a_pop_dec, pop |=> (cnt_q == $past(cnt_m1)), "pop did not decrement count")
  `AST_PROP(a_list_req, (ctrl.op == OP_PITCH) |-> (req_q == REQ_PITCH || req_q == REQ_LIST),
            "pitch step outside pitch or list request")

endmodule
`default_nettype wire

[design/spnh_useq.sv]
// Microcode sequencer: step counter, control table lookup and jump logic.
// Depends on spnh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spnh_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spnh_pkg::stat_t stat_i,
  output spnh_pkg::ucode_t ctrl_o
);
  import spnh_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         w;

  assign w      = ucode_rom(pc_q);
  assign ctrl_o = w;

  always_comb begin
    pc_d = pc_q;
    if (!stat_i.stall) begin
      case (w.cond)
        C_NEXT:     pc_d = pc_q + 1'b1;
        C_ALWAYS:   pc_d = w.target;
        C_PED_NZ:   pc_d = stat_i.ped_nz ? w.target : pc_q + 1'b1;
        C_CNT_Z:    pc_d = stat_i.cnt_z ? w.target : pc_q + 1'b1;
        C_DISPATCH: pc_d = stat_i.accept ? entry_pc(stat_i.req_type) : pc_q;
        default:    pc_d = STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

[verif/tb.sv]
// Testbench for sustain_pedal_note_holder: directed and random request transactions,
// random stalls on both channels and a predictor that checks every note transaction.
// Depends on spnh_pkg, spnh_if and the design files.
`timescale 1ns / 1ps
module tb;
  import spnh_pkg::*;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned ItemTarget = 470;
  localparam int unsigned CalmFrom   = 410;
  localparam logic [ReqW-1:0] ReqReserved = 3'd7;

  typedef struct packed {
    logic [NoteW-1:0] pitch;
    logic [NoteW-1:0] velocity;
    logic             last_of_run;
    logic             overflow;
  } note_t;

  class pedal_scoreboard;
    logic [NoteW-1:0] held[StackDepth];
    int unsigned      held_cnt;
    logic [NoteW-1:0] velocity;
    logic [NoteW-1:0] pedal;
    note_t            notes_due[$];
    int unsigned      errors;

    function new();
      held_cnt = 0;
      velocity = '0;
      pedal    = '0;
      errors   = 0;
    endfunction

    function void emit(logic [NoteW-1:0] pitch, logic [NoteW-1:0] vel, logic ovf);
      notes_due.push_back('{pitch: pitch, velocity: vel, last_of_run: 1'b0, overflow: ovf});
    endfunction

    function void move_pedal(logic [NoteW-1:0] level);
      pedal = level;
      if (pedal == '0) begin
        while (held_cnt > 0) begin
          held_cnt--;
          emit(held[held_cnt], '0, 1'b0);
        end
      end
    endfunction

    function void play_pitch(logic [NoteW-1:0] pitch);
      if (velocity != '0 || pedal == '0) begin
        emit(pitch, velocity, 1'b0);
      end else if (held_cnt < StackDepth) begin
        held[held_cnt] = pitch;
        held_cnt++;
      end else begin
        emit(pitch, '0, 1'b1);
      end
    endfunction

    function void take_request(logic [ReqW-1:0] req, logic [NoteW-1:0] pitch,
                               logic [NoteW-1:0] vel, logic [NoteW-1:0] ped);
      int unsigned was;
      was = notes_due.size();
      case (req)
        REQ_PITCH: play_pitch(pitch);
        REQ_VEL:   velocity = vel;
        REQ_PEDAL: move_pedal(ped);
        REQ_LIST: begin
          move_pedal(ped);
          velocity = vel;
          play_pitch(pitch);
        end
        REQ_CLEAR: held_cnt = 0;
        default: ;
      endcase
      if (notes_due.size() > was) notes_due[notes_due.size()-1].last_of_run = 1'b1;
    endfunction

    function void flag(string field, logic [NoteW-1:0] want, logic [NoteW-1:0] got);
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_note(note_t got);
      note_t want;
      if (notes_due.size() == 0) begin
        $display("%0t: note expected none, got pitch %0d velocity %0d last %0b overflow %0b",
                 $time, got.pitch, got.velocity, got.last_of_run, got.overflow);
        errors++;
        return;
      end
      want = notes_due.pop_front();
      if (got.pitch !== want.pitch) flag("out_pitch", want.pitch, got.pitch);
      if (got.velocity !== want.velocity) flag("out_velocity", want.velocity, got.velocity);
      if (got.last_of_run !== want.last_of_run)
        flag("last_of_run", NoteW'(want.last_of_run), NoteW'(got.last_of_run));
      if (got.overflow !== want.overflow)
        flag("overflow", NoteW'(want.overflow), NoteW'(got.overflow));
    endfunction

    function int unsigned pending();
      return notes_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit calm = 1'b0;
  int unsigned sent_items = 0;
  pedal_scoreboard sb = new();

  spnh_in_if  req_ch ();
  spnh_out_if note_ch ();

  sustain_pedal_note_holder #(.STACK_DEPTH(StackDepth)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (note_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [NoteW-1:0] rand_note();
    return NoteW'($urandom_range(0, 127));
  endfunction

  task automatic send_req(input logic [ReqW-1:0] req, input logic [NoteW-1:0] pitch,
                          input logic [NoteW-1:0] vel, input logic [NoteW-1:0] ped);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= req;
    req_ch.note_pitch    <= pitch;
    req_ch.note_velocity <= vel;
    req_ch.pedal_level   <= ped;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sb.take_request(req, pitch, vel, ped);
    if (req <= REQ_CLEAR) sent_items++;
  endtask

  task automatic wait_notes_out();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // press, play a mix of note-ons and note-offs, then release
  task automatic play_phrase();
    int unsigned steps;
    int unsigned pick;
    steps = $urandom_range(1, 30);
    send_req(REQ_PEDAL, rand_note(), rand_note(), NoteW'($urandom_range(1, 127)));
    repeat (steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_req(REQ_VEL, rand_note(), '0, rand_note());
      end else if (pick < 40) begin
        send_req(REQ_VEL, rand_note(), NoteW'($urandom_range(1, 127)), rand_note());
      end else if (pick < 85) begin
        send_req(REQ_PITCH, rand_note(), rand_note(), rand_note());
      end else begin
        send_req(REQ_LIST, rand_note(), $urandom_range(0, 1) ? '0 : rand_note(),
                 NoteW'($urandom_range(1, 127)));
      end
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      send_req(REQ_PEDAL, rand_note(), rand_note(), '0);
    end else if (pick < 9) begin
      send_req(REQ_LIST, rand_note(), rand_note(), '0);
    end else begin
      send_req(REQ_CLEAR, rand_note(), rand_note(), rand_note());
      send_req(REQ_PEDAL, rand_note(), rand_note(), '0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && note_ch.valid && note_ch.ready) begin
      sb.check_note('{pitch: note_ch.out_pitch, velocity: note_ch.out_velocity,
                      last_of_run: note_ch.last_of_run, overflow: note_ch.overflow});
    end
  end

  initial begin
    note_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      note_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!calm) begin
        note_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned k;
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= '0;
    req_ch.note_pitch    <= '0;
    req_ch.note_velocity <= '0;
    req_ch.pedal_level   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(REQ_PITCH, 7'd127, 7'd0, 7'd0);
    send_req(REQ_VEL, 7'd0, 7'd127, 7'd0);
    send_req(REQ_PITCH, 7'd0, 7'd0, 7'd0);
    send_req(ReqReserved, 7'd127, 7'd127, 7'd127);
    // fill the hold stack, then overflow it
    for (k = 0; k < StackDepth; k++) begin
      send_req(REQ_LIST, NoteW'(k * 7 + 3), 7'd0, 7'd127);
    end
    send_req(REQ_PITCH, 7'd99, 7'd0, 7'd0);
    send_req(REQ_LIST, 7'd5, 7'd1, 7'd0);
    send_req(REQ_LIST, 7'd10, 7'd0, 7'd64);
    send_req(REQ_CLEAR, 7'd0, 7'd0, 7'd0);
    send_req(REQ_PEDAL, 7'd0, 7'd0, 7'd0);
    wait_notes_out();

    while (sent_items < ItemTarget) begin
      calm = sent_items >= CalmFrom;
      play_phrase();
      repeat ($urandom_range(0, 3)) begin
        send_req(ReqW'($urandom_range(0, 7)), rand_note(), rand_note(), rand_note());
      end
      if (!calm && $urandom_range(0, 9) == 0) wait_notes_out();
    end

    wait_notes_out();
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/spnh_pkg.sv
design/spnh_if.sv
design/spnh_useq.sv
design/sustain_pedal_note_holder.sv
verif/tb.sv
